### sv/bil_pkg.sv
// types and constants for the bilinear repeat-wrap texture sampler
// no dependencies
`default_nettype none
package bil_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] texel_address;
        logic [7:0]  texel_red;
        logic [7:0]  texel_green;
        logic [7:0]  texel_blue;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
    } t_in_word;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } t_out_word;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

endpackage
`default_nettype wire

### sv/bilinear_repeat_texture_sampler.sv
// top level of the bilinear repeat-wrap texture sampler: texel memory and filter pipeline
// depends on bil_pkg
//
// One word is taken in every cycle: busy never rises. A write word stores a texel and gives
// no result; a sample word gives its filtered color on o_out with o_valid high for one cycle,
// in the order the words came. The receiver cannot stall.
// Two copies of the texel memory, each read at two addresses per cycle, serve all four
// neighbors at once; writes pass down the same pipeline as samples and reach the memory in
// the read stage, so order is kept without interlock. The texel memory is not cleared after
// reset: a texel that was never written reads as anything. Register 0 (width) lies at byte 0,
// register 1 (height) at byte 4.
`default_nettype none
module bilinear_repeat_texture_sampler
    import bil_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int MAX_TEXELS = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_in_word    i_in,
    output logic             o_valid,
    output t_out_word        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int EW = (DW > 9) ? DW : 9;
    localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
    localparam int PW = 2 * DW;
    localparam int RS = PW + AW;
    localparam int RW = PW + 2;
    localparam int QW = PW + RW;
    localparam int TW = PW + AW + 1;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << RS) / 64'(MAX_TEXELS));

    logic [23:0] mem_a [MAX_TEXELS];
    logic [23:0] mem_b [MAX_TEXELS];

    logic [8:0] r_tex_width, r_tex_height;
    logic [EW-1:0] w_ext, h_ext;
    logic [DW-1:0] w_eff, h_eff;

    // pipeline
    logic          r_wr   [1:5];
    logic [AW-1:0] r_widx [1:5];
    logic [23:0]   r_wdat [1:5];
    logic          r_smp  [1:8];
    logic [7:0]    r_fx   [2:7];
    logic [7:0]    r_fy   [2:7];
    logic [15:0]   r1_fu, r1_fv;
    logic [DW-1:0] r2_x0, r2_y0;
    logic [PW-1:0] r3_a [4];
    logic [PW-1:0] r4_a [4];
    logic [PW-1:0] r4_q [4];
    logic [AW-1:0] r5_idx [4];
    logic [23:0]   r6_t [4];
    logic [15:0]   r7_row0 [3];
    logic [15:0]   r7_row1 [3];
    logic [15:0]   r8_out [3];

    logic [16+DW-1:0] su, sv;
    logic [DW-1:0]    x1, y1;
    logic [PW-1:0]    row0w, row1w;
    logic [PW-1:0]    n_a [4];
    logic [PW-1:0]    n_q [4];
    logic [AW-1:0]    n_idx [4];
    logic [15:0]      n_row0 [3];
    logic [15:0]      n_row1 [3];
    logic [15:0]      n_out [3];
    logic             in_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = {23'd0, (paddr[2] == REG_HEIGHT) ? r_tex_height : r_tex_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= 9'd1;
            r_tex_height <= 9'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_WIDTH) begin
                r_tex_width <= pwdata[8:0];
            end else begin
                r_tex_height <= pwdata[8:0];
            end
        end
    end

    // dimension clamp
    always_comb begin
        w_ext = EW'(r_tex_width);
        h_ext = EW'(r_tex_height);
        if (w_ext == '0) w_eff = DW'(1);
        else if (w_ext > EW'(MAX_DIM)) w_eff = DW'(MAX_DIM);
        else w_eff = DW'(w_ext);
        if (h_ext == '0) h_eff = DW'(1);
        else if (h_ext > EW'(MAX_DIM)) h_eff = DW'(MAX_DIM);
        else h_eff = DW'(h_ext);
    end

    assign in_wr = start && (i_in.mode == MODE_WRITE)
                   && (32'(i_in.texel_address) < 32'(MAX_TEXELS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 5; k++) r_wr[k] <= 1'b0;
            for (int k = 1; k <= 8; k++) r_smp[k] <= 1'b0;
        end else begin
            r_wr[1]  <= in_wr;
            r_smp[1] <= start && (i_in.mode == MODE_SAMPLE);
            for (int k = 2; k <= 5; k++) r_wr[k] <= r_wr[k-1];
            for (int k = 2; k <= 8; k++) r_smp[k] <= r_smp[k-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_widx[1] <= AW'(32'(i_in.texel_address));
        r_wdat[1] <= {i_in.texel_red, i_in.texel_green, i_in.texel_blue};
        for (int k = 2; k <= 5; k++) begin
            r_widx[k] <= r_widx[k-1];
            r_wdat[k] <= r_wdat[k-1];
        end
        r1_fu <= i_in.coord_u[15:0];
        r1_fv <= i_in.coord_v[15:0];
        r2_x0 <= DW'(su >> 16);
        r2_y0 <= DW'(sv >> 16);
        r_fx[2] <= su[15:8];
        r_fy[2] <= sv[15:8];
        for (int k = 3; k <= 7; k++) begin
            r_fx[k] <= r_fx[k-1];
            r_fy[k] <= r_fy[k-1];
        end
        for (int k = 0; k < 4; k++) begin
            r3_a[k]   <= n_a[k];
            r4_a[k]   <= r3_a[k];
            r4_q[k]   <= n_q[k];
            r5_idx[k] <= n_idx[k];
        end
        for (int c = 0; c < 3; c++) begin
            r7_row0[c] <= n_row0[c];
            r7_row1[c] <= n_row1[c];
            r8_out[c]  <= n_out[c];
        end
    end

    // scale and neighbor addresses
    always_comb begin
        su = (16+DW)'(r1_fu) * (16+DW)'(w_eff);
        sv = (16+DW)'(r1_fv) * (16+DW)'(h_eff);
        x1 = ((DW+1)'(r2_x0) + (DW+1)'(1) < (DW+1)'(w_eff)) ? r2_x0 + DW'(1) : w_eff - DW'(1);
        y1 = ((DW+1)'(r2_y0) + (DW+1)'(1) < (DW+1)'(h_eff)) ? r2_y0 + DW'(1) : h_eff - DW'(1);
        row0w = PW'(r2_y0) * PW'(w_eff);
        row1w = PW'(y1) * PW'(w_eff);
        n_a[0] = row0w + PW'(r2_x0);
        n_a[1] = row0w + PW'(x1);
        n_a[2] = row1w + PW'(r2_x0);
        n_a[3] = row1w + PW'(x1);
    end

    // address wrap by reciprocal
    always_comb begin
        logic [TW-1:0] rem;
        rem = '0;
        for (int k = 0; k < 4; k++) begin
            n_q[k] = PW'((QW'(r3_a[k]) * QW'(RECIP)) >> RS);
            rem = TW'(r4_a[k]) - TW'(r4_q[k]) * TW'(MAX_TEXELS);
            if (rem >= TW'(MAX_TEXELS)) rem = rem - TW'(MAX_TEXELS);
            n_idx[k] = AW'(rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wr[5]) begin
            mem_a[r_widx[5]] <= r_wdat[5];
            mem_b[r_widx[5]] <= r_wdat[5];
        end
        r6_t[0] <= mem_a[r5_idx[0]];
        r6_t[1] <= mem_a[r5_idx[1]];
        r6_t[2] <= mem_b[r5_idx[2]];
        r6_t[3] <= mem_b[r5_idx[3]];
    end

    // bilinear blend
    always_comb begin
        logic [8:0] wx0, wx1, wy0, wy1;
        wx1 = 9'(r_fx[6]);
        wx0 = 9'd256 - wx1;
        wy1 = 9'(r_fy[7]);
        wy0 = 9'd256 - wy1;
        for (int c = 0; c < 3; c++) begin
            n_row0[c] = 16'(17'(r6_t[0][16-8*c +: 8]) * 17'(wx0)
                          + 17'(r6_t[1][16-8*c +: 8]) * 17'(wx1));
            n_row1[c] = 16'(17'(r6_t[2][16-8*c +: 8]) * 17'(wx0)
                          + 17'(r6_t[3][16-8*c +: 8]) * 17'(wx1));
            n_out[c] = 16'((25'(r7_row0[c]) * 25'(wy0) + 25'(r7_row1[c]) * 25'(wy1)) >> 8);
        end
    end

    assign o_valid         = r_smp[8];
    assign o_out.out_red   = r8_out[0];
    assign o_out.out_green = r8_out[1];
    assign o_out.out_blue  = r8_out[2];

endmodule
`default_nettype wire

### verif/tb_top.sv
// testbench for bilinear_repeat_texture_sampler: texel writes and filtered samples checked
// against an in-bench filter model; depends on bil_pkg and the sampler top level
`timescale 1ns / 100ps
module tb_top;
    import bil_pkg::*;

    localparam logic [2:0] ADDR_WIDTH   = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT  = 3'd4;
    localparam int DIM_LIMIT  = 256;
    localparam int TEXEL_CNT  = 65536;
    localparam int FILL_CNT   = 1024;
    localparam int DRAIN_CYC  = 12;
    localparam int IN_BITS    = $bits(t_in_word);

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in_word    i_in;
    logic        o_valid;
    t_out_word   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [23:0] texel_mem [0:TEXEL_CNT-1];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    t_out_word   expected_colors[$];
    int          mismatches;
    bit          idling_on;

    bilinear_repeat_texture_sampler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_valid(o_valid), .o_out(o_out), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int clamp_dim(logic [8:0] d);
        if (d == 0) return 1;
        if (d > DIM_LIMIT) return DIM_LIMIT;
        return int'(d);
    endfunction

    function automatic t_out_word filter_sample(logic [31:0] u, logic [31:0] v);
        int unsigned w, h, su, sv, x0, y0, x1, y1, fx, fy, r0, r1, c;
        logic [23:0] t00, t10, t01, t11;
        t_out_word res;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        su = u[15:0] * w;
        sv = v[15:0] * h;
        x0 = su >> 16;
        y0 = sv >> 16;
        fx = (su >> 8) & 8'hFF;
        fy = (sv >> 8) & 8'hFF;
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        t00 = texel_mem[(y0 * w + x0) % TEXEL_CNT];
        t10 = texel_mem[(y0 * w + x1) % TEXEL_CNT];
        t01 = texel_mem[(y1 * w + x0) % TEXEL_CNT];
        t11 = texel_mem[(y1 * w + x1) % TEXEL_CNT];
        for (int k = 0; k < 3; k++) begin
            r0 = t00[16-8*k +: 8] * (256 - fx) + t10[16-8*k +: 8] * fx;
            r1 = t01[16-8*k +: 8] * (256 - fx) + t11[16-8*k +: 8] * fx;
            c = (r0 * (256 - fy) + r1 * fy) >> 8;
            if (k == 0) res.out_red = c[15:0];
            else if (k == 1) res.out_green = c[15:0];
            else res.out_blue = c[15:0];
        end
        return res;
    endfunction

    task automatic idle_gap();
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic send_word(t_in_word w);
        idle_gap();
        start = 1'b1;
        i_in = w;
        do @(posedge i_clk); while (busy);
        if (w.mode == MODE_WRITE) texel_mem[w.texel_address] = {w.texel_red, w.texel_green,
                                                                 w.texel_blue};
        else expected_colors.push_back(filter_sample(w.coord_u, w.coord_v));
        @(negedge i_clk);
    endtask

    task automatic write_texel(logic [15:0] a, logic [23:0] rgb);
        t_in_word w;
        w = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
        w.mode = MODE_WRITE;
        w.texel_address = a;
        {w.texel_red, w.texel_green, w.texel_blue} = rgb;
        send_word(w);
    endtask

    task automatic sample_at(logic [31:0] u, logic [31:0] v);
        t_in_word w;
        w = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
        w.mode = MODE_SAMPLE;
        w.coord_u = u;
        w.coord_v = v;
        send_word(w);
    endtask

    task automatic drain();
        start = 1'b0;
        while (expected_colors.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] a, logic [31:0] d);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = a;
        pwdata = d;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (a == ADDR_WIDTH) width_reg = d[8:0];
        else if (a == ADDR_HEIGHT) height_reg = d[8:0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_dims(logic [31:0] w, logic [31:0] h);
        drain();
        write_reg(ADDR_WIDTH, w);
        write_reg(ADDR_HEIGHT, h);
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid) begin
            if (expected_colors.size() == 0) begin
                $error("unexpected result %h", o_out);
                mismatches++;
            end else begin
                exp_w = expected_colors.pop_front();
                if (o_out.out_red !== exp_w.out_red) begin
                    $error("out_red exp %h got %h", exp_w.out_red, o_out.out_red);
                    mismatches++;
                end
                if (o_out.out_green !== exp_w.out_green) begin
                    $error("out_green exp %h got %h", exp_w.out_green, o_out.out_green);
                    mismatches++;
                end
                if (o_out.out_blue !== exp_w.out_blue) begin
                    $error("out_blue exp %h got %h", exp_w.out_blue, o_out.out_blue);
                    mismatches++;
                end
            end
        end
    end

    // every texel a sample can reach gets written first; dimensions stay within that area
    task automatic test_fill();
        idling_on = 1'b0;
        for (int a = 0; a < FILL_CNT; a++) write_texel(a[15:0], 24'($urandom));
        idling_on = 1'b1;
    endtask

    task automatic test_directed();
        set_dims(32, 32);
        write_texel(16'h0000, 24'h000000);
        write_texel(16'hFFFF, 24'hFFFFFF);
        write_texel(16'h0001, 24'hFFFFFF);
        write_texel(16'h0020, 24'hFF00FF);
        sample_at(32'h0000_0000, 32'h0000_0000);
        sample_at(32'h0000_FFFF, 32'h0000_FFFF);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'hFFFF_FFFF, 32'hFFFF_0000);
        sample_at(32'h0000_0080, 32'h0000_0080);
        sample_at(32'h1234_8000, 32'hFEDC_8000);
        write_texel(16'h0000, 24'hFFFFFF);
        sample_at(32'h0000_0080, 32'h0000_0040);
        set_dims(1, 1);
        sample_at(32'h0000_FFFF, 32'hFFFF_FFFF);
        sample_at(32'h0000_0000, 32'h8000_0000);
        set_dims(0, 0);
        sample_at(32'h0000_7FFF, 32'h0000_C000);
        set_dims(511, 2);
        sample_at(32'h0000_FFFF, 32'h0000_FFFF);
        sample_at(32'h0000_4321, 32'h0000_8765);
        set_dims(2, 257);
        sample_at(32'h0000_FFFF, 32'h0000_FFFF);
        sample_at(32'h0000_4321, 32'h0000_8765);
        set_dims(3, 200);
        sample_at(32'h0000_FFFF, 32'h0000_FFFF);
        set_dims(256, 1);
        sample_at(32'h0000_FF00, 32'h0000_5555);
        set_dims(1, 256);
        sample_at(32'h0000_5555, 32'h0000_FF00);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) write_texel(16'($urandom), 24'($urandom));
            else if ($urandom_range(0, 4) == 0)
                sample_at({16'($urandom_range(0, 65535)),
                           16'(32'hFFFF - $urandom_range(0, 255))}, $urandom);
            else sample_at($urandom, $urandom);
        end
    endtask

    task automatic test_random();
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_dims(256, 4);
                1: set_dims(1, 1);
                2: set_dims($urandom_range(1, 8), $urandom_range(1, 8));
                3: set_dims($urandom_range(0, 511), $urandom_range(0, 4));
                4: set_dims($urandom_range(0, 4), $urandom_range(0, 511));
                default: set_dims($urandom_range(1, 32), $urandom_range(1, 32));
            endcase
            if (p == 7) idling_on = 1'b0;
            random_phase(120);
        end
        drain();
    endtask

    initial begin
        start = 1'b0;
        i_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        width_reg = 9'd1;
        height_reg = 9'd1;
        mismatches = 0;
        idling_on = 1'b1;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_fill();
        test_directed();
        test_random();
        if (mismatches == 0 && expected_colors.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
